// File: design/pcrs_pkg.sv
// shared types and constants of the philox counter random stream
package pcrs_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 72;

	// philox4x32 multipliers and key increments
	localparam logic [WORD_W-1:0] PHILOX_M0 = 32'hD251_1F53;
	localparam logic [WORD_W-1:0] PHILOX_M1 = 32'hCD9E_8D57;
	localparam logic [WORD_W-1:0] PHILOX_W0 = 32'h9E37_79B9;
	localparam logic [WORD_W-1:0] PHILOX_W1 = 32'hBB67_AE85;

	localparam logic [1:0] MAX_WORD = 2'd3;

	// command codes carried in tuser
	localparam logic CMD_PICK = 1'b0;
	localparam logic CMD_SEEK = 1'b1;

	typedef enum logic [1:0] {
		REG_GLOBAL_INDEX = 2'd0,
		REG_STREAM_ID1   = 2'd1,
		REG_STREAM_ID2   = 2'd2,
		REG_STREAM_ID3   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_IDLE
	} state_t;

	typedef struct packed {
		logic accept;    // take the input beat and load the output register
		logic cfg_load;  // rebuild the counter from the id registers and start the cipher
		logic round;     // run one cipher round
	} ctrl_cmd_t;

	typedef struct packed {
		logic item_ciphers;  // pending beat is a seek or the fourth pick
		logic last_round;    // round counter sits on the final round
	} dp_status_t;

endpackage

// File: design/pcrs_ctrl.sv
// controller state machine: handshakes, cipher sequencing and output valid
module pcrs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic                    cfg_we,
	input  pcrs_pkg::dp_status_t    status,
	output pcrs_pkg::ctrl_cmd_t     cmd
);

	pcrs_pkg::state_t state_q;
	pcrs_pkg::state_t state_nx;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcrs_pkg::ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx     = state_q;
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.cfg_load = 1'b0;
		cmd.round    = 1'b0;
		unique case (state_q)
			pcrs_pkg::ST_LOAD: begin
				cmd.cfg_load = 1'b1;
				state_nx     = pcrs_pkg::ST_RUN;
			end
			pcrs_pkg::ST_RUN: begin
				cmd.round = 1'b1;
				if (status.last_round) begin
					state_nx = pcrs_pkg::ST_IDLE;
				end
			end
			pcrs_pkg::ST_IDLE: begin
				s_tready   = !out_valid_q || m_tready;
				cmd.accept = s_tvalid && s_tready;
				if (cmd.accept && status.item_ciphers) begin
					state_nx = pcrs_pkg::ST_RUN;
				end
			end
			default: begin
				state_nx = pcrs_pkg::ST_LOAD;
			end
		endcase
		// a register write restarts the stream
		if (cfg_we) begin
			state_nx = pcrs_pkg::ST_LOAD;
		end
	end

	assign m_tvalid = out_valid_q;

	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pcrs_pkg::ST_IDLE) |-> !s_tready)
		else $error("input ready while cipher busy");

	a_cipher_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && status.item_ciphers && !cfg_we) |=> (state_q == pcrs_pkg::ST_RUN))
		else $error("seek or fourth pick did not start the cipher");

	a_accept_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> m_tvalid)
		else $error("accepted beat produced no output");

endmodule

// File: design/pcrs_datapath.sv
// datapath: config registers, counter, word index, philox round unit, output register
module pcrs_datapath #(
	parameter int unsigned ROUNDS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tuser,
	input  logic [pcrs_pkg::IN_DATA_W-1:0]        s_tdata,
	output logic [pcrs_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [pcrs_pkg::WORD_W-1:0]           cfg_data,
	input  pcrs_pkg::ctrl_cmd_t                   cmd,
	output pcrs_pkg::dp_status_t                  status
);

	localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

	logic [pcrs_pkg::WORD_W-1:0] global_index_q;
	logic [pcrs_pkg::WORD_W-1:0] stream_id1_q;
	logic [pcrs_pkg::WORD_W-1:0] stream_id2_q;
	logic [pcrs_pkg::WORD_W-1:0] stream_id3_q;

	logic [3:0][pcrs_pkg::WORD_W-1:0] ctr_q;
	logic [3:0][pcrs_pkg::WORD_W-1:0] x_q;
	logic [pcrs_pkg::WORD_W-1:0]      k0_q;
	logic [pcrs_pkg::WORD_W-1:0]      k1_q;
	logic [RND_W-1:0]                 rnd_q;
	logic [1:0]                       wi_q;
	logic [pcrs_pkg::OUT_DATA_W-1:0]  out_q;

	logic [pcrs_pkg::WORD_W-1:0]      seek_seq;
	logic [7:0]                       seek_word;
	logic                             is_seek;
	logic [3:0][pcrs_pkg::WORD_W-1:0] ctr_inc;
	logic [3:0][pcrs_pkg::WORD_W-1:0] ctr_nx;
	logic [3:0][pcrs_pkg::WORD_W-1:0] ctr_ld;
	logic [1:0]                       wi_nx;
	logic [pcrs_pkg::WORD_W-1:0]      value;
	logic [2*pcrs_pkg::WORD_W-1:0]    p0;
	logic [2*pcrs_pkg::WORD_W-1:0]    p1;

	assign seek_seq  = s_tdata[31:0];
	assign seek_word = s_tdata[39:32];
	assign is_seek   = (s_tuser == pcrs_pkg::CMD_SEEK);
	assign ctr_inc   = ctr_q + 128'd1;
	assign ctr_ld    = {stream_id2_q, stream_id1_q, stream_id3_q, 32'd0};

	always_comb begin
		ctr_nx = ctr_q;
		wi_nx  = wi_q + 2'd1;
		value  = x_q[wi_q];
		if (is_seek) begin
			ctr_nx[0] = seek_seq;
			value     = '0;
			// negative or above three falls back to word zero
			wi_nx     = (seek_word[7:2] == 6'd0) ? seek_word[1:0] : 2'd0;
		end else if (wi_q == pcrs_pkg::MAX_WORD) begin
			ctr_nx = ctr_inc;
			wi_nx  = 2'd0;
		end
	end

	assign status.item_ciphers = is_seek || (wi_q == pcrs_pkg::MAX_WORD);
	assign status.last_round   = (rnd_q == LAST_RND);

	assign p0 = {32'd0, pcrs_pkg::PHILOX_M0} * {32'd0, x_q[0]};
	assign p1 = {32'd0, pcrs_pkg::PHILOX_M1} * {32'd0, x_q[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_index_q <= '0;
			stream_id1_q   <= '0;
			stream_id2_q   <= '0;
			stream_id3_q   <= '0;
			ctr_q          <= '0;
			wi_q           <= '0;
			rnd_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (pcrs_pkg::reg_idx_t'(cfg_index))
					pcrs_pkg::REG_GLOBAL_INDEX: global_index_q <= cfg_data;
					pcrs_pkg::REG_STREAM_ID1:   stream_id1_q   <= cfg_data;
					pcrs_pkg::REG_STREAM_ID2:   stream_id2_q   <= cfg_data;
					pcrs_pkg::REG_STREAM_ID3:   stream_id3_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.cfg_load) begin
				ctr_q <= ctr_ld;
				wi_q  <= 2'd0;
				rnd_q <= '0;
			end else if (cmd.accept) begin
				ctr_q <= ctr_nx;
				wi_q  <= wi_nx;
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + RND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cfg_load) begin
			x_q  <= ctr_ld;
			k0_q <= global_index_q;
			k1_q <= '0;
		end else if (cmd.accept && status.item_ciphers) begin
			x_q  <= ctr_nx;
			k0_q <= global_index_q;
			k1_q <= '0;
		end else if (cmd.round) begin
			x_q[0] <= p1[63:32] ^ x_q[1] ^ k0_q;
			x_q[1] <= p1[31:0];
			x_q[2] <= p0[63:32] ^ x_q[3] ^ k1_q;
			x_q[3] <= p0[31:0];
			k0_q   <= k0_q + pcrs_pkg::PHILOX_W0;
			k1_q   <= k1_q + pcrs_pkg::PHILOX_W1;
		end
		if (cmd.accept) begin
			out_q <= {6'd0, wi_nx, ctr_nx[0], value};
		end
	end

	assign m_tdata = out_q;

	a_pick_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !status.item_ciphers && !cmd.cfg_load) |=> (wi_q == $past(wi_q) + 2'd1))
		else $error("pick did not advance the word index");

	a_load_clears_round: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cfg_load |=> (rnd_q == '0 && wi_q == 2'd0))
		else $error("restart left round or word index set");

	a_wrap_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !is_seek && wi_q == pcrs_pkg::MAX_WORD && !cmd.cfg_load)
		|=> (ctr_q[0] == $past(ctr_q[0]) + 32'd1))
		else $error("fourth pick did not bump the counter");

endmodule

// File: design/philox_counter_random_stream_unit.sv
// top level of the philox4x32 counter based random stream
//
// channel | dir | beat fields (lowest bit first)
// s_*     | in  | tuser: cmd ; tdata: seek_sequence[31:0], seek_word[39:32]
// m_*     | out | tdata: value[31:0], sequence_now[63:32], word_now[65:64], zero pad
// cfg_*   | in  | cfg_we, cfg_index (register), cfg_data (32 bit value)
//
// a pick of words zero to two runs no cipher; the unit stays ready for the next beat
// a seek or the fourth pick enciphers the new counter, one philox round per cycle in the
// shared round unit (two 32x32 multipliers), input ready stays low meanwhile
// after reset and after every register write the counter is rebuilt and enciphered
// before the first beat is taken; a stalled output holds in its register; a new beat is
// taken once the register frees or drains in the same cycle
module philox_counter_random_stream_unit #(
	parameter int unsigned ROUNDS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pcrs_pkg::IN_DATA_W-1:0]   s_tdata,   // seek_sequence, seek_word
	input  logic                             s_tuser,   // cmd: pick or seek
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pcrs_pkg::OUT_DATA_W-1:0]  m_tdata,   // value, sequence_now, word_now
	// register writes
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [pcrs_pkg::WORD_W-1:0]      cfg_data
);

	// command and status between the state machine and the datapath
	pcrs_pkg::ctrl_cmd_t  cmd;
	pcrs_pkg::dp_status_t status;

	// state machine: accepts beats, sequences cipher rounds, owns output valid
	pcrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: registers, 128 bit counter, round unit, output register
	pcrs_datapath #(
		.ROUNDS (ROUNDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
